// ===== rtl/core/utf8_to_utf16_transcoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder assertion macros
// Concurrent assertion wrappers shared by the transcoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH

// Assert with an explicit clock and active-low reset.
`define U8U16_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert on the default clock and reset of the transcoder.
`define U8U16_ASSERT(lbl, prop, msg) \
  `U8U16_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Result record, result set and code constants shared by the transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Most results one byte can cause: two surrogate units and a summary.
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResCntW    = 2;

  localparam logic [30:0] CpMax      = 31'h0010_FFFF;
  localparam logic [19:0] SurrBlock  = 20'h0001B;   // cp[30:11] of 0xD800..0xDFFF
  localparam logic [20:0] SuppBase   = 21'h01_0000;
  localparam logic [15:0] SurrHiBase = 16'hD800;
  localparam logic [15:0] SurrLoBase = 16'hDC00;

  typedef enum logic {
    KIND_UNIT    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] code_unit;
    logic [15:0] total_units;
    logic        overflow;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [ResCntW-1:0]           cnt;
    result_t [MaxResults-1:0]     res;
  } res_set_t;

endpackage

// ===== rtl/core/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode stage
// Holds the sequence state and turns one byte into its set of results.
// ----------------------------------------------------------------------------
module u8u16_decode import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        commit_i,
  input  logic [7:0]  byte_i,
  input  logic        eot_i,
  input  logic [15:0] limit_i,
  output res_set_t    set_o
);

  logic [30:0] pc_q, pc_d;
  logic [2:0]  rem_q, rem_d;
  logic [15:0] cnt_q, cnt_d, cnt_upd;
  logic        ovf_q, ovf_d, ovf_upd;

  logic        cont, take, need2, bad;
  logic [30:0] pc_upd, cp;
  logic [2:0]  rem_upd;
  logic [20:0] v;
  logic [16:0] sum;
  logic [1:0]  n_units;
  logic [15:0] unit0, unit1;
  logic [ResCntW-1:0] n_res;
  result_t [MaxResults-1:0] res;

  always_comb begin
    pc_upd  = pc_q;
    rem_upd = rem_q;
    take    = 1'b0;
    cp      = '0;
    cont    = (rem_q != 3'd0) && (byte_i[7:6] == 2'b10);
    if (cont) begin
      pc_upd  = {pc_q[24:0], byte_i[5:0]};
      rem_upd = rem_q - 3'd1;
      if (rem_upd == 3'd0) begin
        take   = 1'b1;
        cp     = pc_upd;
        pc_upd = '0;
      end
    end else begin
      pc_upd  = '0;
      rem_upd = 3'd0;
      unique casez (byte_i)
        8'b0???_????: begin
          take = 1'b1;
          cp   = {23'd0, byte_i};
        end
        8'b110?_????: begin
          pc_upd  = {26'd0, byte_i[4:0]};
          rem_upd = 3'd1;
        end
        8'b1110_????: begin
          pc_upd  = {27'd0, byte_i[3:0]};
          rem_upd = 3'd2;
        end
        8'b1111_0???: begin
          pc_upd  = {28'd0, byte_i[2:0]};
          rem_upd = 3'd3;
        end
        8'b1111_10??: begin
          pc_upd  = {29'd0, byte_i[1:0]};
          rem_upd = 3'd4;
        end
        8'b1111_110?: begin
          pc_upd  = {30'd0, byte_i[0]};
          rem_upd = 3'd5;
        end
        default: ;  // stray continuation, 0xFE, 0xFF: skip
      endcase
    end
  end

  // Code point check, capacity and unit forming.
  always_comb begin
    need2   = (cp[30:16] != 15'd0);
    bad     = (cp > CpMax) || (cp[30:11] == SurrBlock);
    v       = cp[20:0] - SuppBase;
    sum     = {1'b0, cnt_q} + (need2 ? 17'd2 : 17'd1);
    cnt_upd = cnt_q;
    ovf_upd = ovf_q;
    n_units = 2'd0;
    if (take && !ovf_q && !bad) begin
      if (limit_i == 16'd0) begin
        cnt_upd = sum[16] ? 16'hFFFF : sum[15:0];
      end else if (sum > {1'b0, limit_i}) begin
        ovf_upd = 1'b1;
      end else begin
        cnt_upd = sum[15:0];
        n_units = need2 ? 2'd2 : 2'd1;
      end
    end
    unit0 = need2 ? (SurrHiBase | {6'd0, v[19:10]}) : cp[15:0];
    unit1 = SurrLoBase | {6'd0, v[9:0]};
  end

  // Pack units first, summary after them, mark the last one.
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '{kind: KIND_UNIT, code_unit: 16'd0, total_units: 16'd0,
                 overflow: 1'b0, run_last: 1'b0};
    end
    if (n_units != 2'd0) res[0].code_unit = unit0;
    if (n_units == 2'd2) res[1].code_unit = unit1;
    if (eot_i) begin
      res[n_units].kind        = KIND_SUMMARY;
      res[n_units].total_units = ovf_upd ? 16'd0 : cnt_upd;
      res[n_units].overflow    = ovf_upd;
    end
    n_res = n_units + {1'b0, eot_i};
    if (n_res != '0) res[n_res - 2'd1].run_last = 1'b1;
  end

  // End of string clears the whole sequence state.
  assign pc_d  = eot_i ? '0 : pc_upd;
  assign rem_d = eot_i ? 3'd0 : rem_upd;
  assign cnt_d = eot_i ? 16'd0 : cnt_upd;
  assign ovf_d = eot_i ? 1'b0 : ovf_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      rem_q <= 3'd0;
      cnt_q <= 16'd0;
      ovf_q <= 1'b0;
    end else if (commit_i) begin
      pc_q  <= pc_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign set_o.cnt = n_res;
  assign set_o.res = res;

endmodule

// ===== rtl/core/u8u16_resq.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Holds the results of one byte and hands them out one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module u8u16_resq import u8u16_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  res_set_t set_i,
  input  logic     out_ready_i,
  output result_t  head_o,
  output logic     valid_o,
  output logic     free_o
);

  result_t [MaxResults-1:0] res_q;
  logic [ResCntW-1:0]       cnt_q;
  logic                     pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && out_ready_i;
  // Free when empty or when the last entry leaves this cycle.
  assign free_o  = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_ready_i);
  assign head_o  = res_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= set_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= set_i.res;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

endmodule

// ===== rtl/core/utf8_to_utf16_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream into UTF-16 code units and a per-string summary.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Dir | Meaning
//  --------+-------------------------------------------+-----+------------------
//  in      | in_valid_i/in_ready_o, in_byte_i,         | in  | one byte per item
//          | end_of_text_i                             |     |
//  out     | out_valid_o/out_ready_i, result_kind_o,   | out | unit or summary
//          | code_unit_o, total_units_o, overflow_o,   |     |
//          | run_last_o                                |     |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_data_i       | in  | unit_limit write
//
// A byte is held in the input register until the result queue can take its
// results; it is then decoded into the queue, from whose head they leave.
// Throughput is one byte per cycle while each byte gives at most one result
// and the output is ready; a byte that gives two or three results holds the
// input register while the result queue drains one item per ready cycle.
// Reset clears the sequence state, the unit count, the limit and all valids.
// A stalled output backs up through the queue into the input register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [15:0] code_unit_o,
  output logic [15:0] total_units_o,
  output logic        overflow_o,
  output logic        run_last_o,
  // unit_limit write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

`include "utf8_to_utf16_transcoder_unit_macros.svh"

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        eot_q;
  logic [15:0] limit_q;
  logic        commit;
  logic        q_free;
  res_set_t    dec_set;
  result_t     head;

  // Configuration is always accepted; the user must change it only between
  // strings or between code points, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'd0;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Advance the held byte into the queue once the queue can take its results.
  assign commit     = in_vld_q && q_free;
  assign in_ready_o = !in_vld_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (commit) begin
      in_vld_q <= 1'b0;
    end
  end

  // Payload needs no reset; hold it until the next accepted item.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      eot_q     <= end_of_text_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .byte_i   (in_byte_q),
    .eot_i    (eot_q),
    .limit_i  (limit_q),
    .set_o    (dec_set)
  );

  u8u16_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (commit),
    .set_i       (dec_set),
    .out_ready_i (out_ready_i),
    .head_o      (head),
    .valid_o     (out_valid_o),
    .free_o      (q_free)
  );

  assign result_kind_o = head.kind;
  assign code_unit_o   = head.code_unit;
  assign total_units_o = head.total_units;
  assign overflow_o    = head.overflow;
  assign run_last_o    = head.run_last;

  // A held byte that cannot move into the queue stays held.
  `U8U16_ASSERT(a_hold_blocked, in_vld_q && !q_free |=> in_vld_q, "held byte lost")
  // The summary always closes the results of its byte.
  `U8U16_ASSERT(a_summary_last, out_valid_o && result_kind_o == KIND_SUMMARY |-> run_last_o, "summary not last")
  // An overflowed string reports a total of zero.
  `U8U16_ASSERT(a_ovf_total, out_valid_o && overflow_o |-> total_units_o == 16'd0, "overflow with nonzero total")
  // Code unit items never carry the overflow flag.
  `U8U16_ASSERT(a_unit_no_ovf, out_valid_o && result_kind_o == KIND_UNIT |-> !overflow_o, "unit item flags overflow")

endmodule

// ===== dv/utf8_to_utf16_transcoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder checker
// Watches the byte, result and limit channels, decodes every accepted byte
// on its own copy of the sequence state, and compares each accepted result
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_checker import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        result_kind_i,
  input  logic [15:0] code_unit_i,
  input  logic [15:0] total_units_i,
  input  logic        overflow_i,
  input  logic        run_last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          expected_left_o,
  output int          units_seen_o,
  output int          summaries_seen_o,
  output int          overflows_seen_o
);

  result_t     pending_units_q[$];
  logic [15:0] limit_copy     = '0;
  logic [30:0] partial_cp     = '0;
  logic [2:0]  cont_left      = '0;
  logic [15:0] units_in_text  = '0;
  logic        capacity_hit   = 1'b0;
  int          errors         = 0;
  int          n_units        = 0;
  int          n_summaries    = 0;
  int          n_overflows    = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("%0t: result mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic queue_unit(input logic [15:0] unit);
    result_t r;
    r.kind        = KIND_UNIT;
    r.code_unit   = unit;
    r.total_units = '0;
    r.overflow    = 1'b0;
    r.run_last    = 1'b0;
    pending_units_q.push_back(r);
  endtask

  // Turn a finished code point into units, or count or drop it.
  task automatic emit_code_point(input logic [30:0] cp);
    logic [20:0] offset;
    int unsigned need;
    int unsigned sum;
    if (capacity_hit) return;
    if (cp > CpMax || cp[30:11] == SurrBlock) return;
    need = (cp >= 31'h1_0000) ? 2 : 1;
    if (limit_copy == 16'd0) begin
      sum = units_in_text + need;
      units_in_text = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
      return;
    end
    if (units_in_text + need > limit_copy) begin
      capacity_hit = 1'b1;
      return;
    end
    if (need == 2) begin
      offset = cp[20:0] - SuppBase;
      queue_unit(SurrHiBase | {6'd0, offset[19:10]});
      queue_unit(SurrLoBase | {6'd0, offset[9:0]});
    end else begin
      queue_unit(cp[15:0]);
    end
    units_in_text = units_in_text + need[15:0];
  endtask

  task automatic start_lead(input logic [7:0] b);
    partial_cp = '0;
    cont_left  = '0;
    casez (b)
      8'b0???????: emit_code_point({23'd0, b});
      8'b110?????: begin
        partial_cp = {26'd0, b[4:0]};
        cont_left  = 3'd1;
      end
      8'b1110????: begin
        partial_cp = {27'd0, b[3:0]};
        cont_left  = 3'd2;
      end
      8'b11110???: begin
        partial_cp = {28'd0, b[2:0]};
        cont_left  = 3'd3;
      end
      8'b111110??: begin
        partial_cp = {29'd0, b[1:0]};
        cont_left  = 3'd4;
      end
      8'b1111110?: begin
        partial_cp = {30'd0, b[0]};
        cont_left  = 3'd5;
      end
      default: ;  // stray continuation byte, 0xFE or 0xFF: skip
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    result_t r;
    int      first;
    first = pending_units_q.size();
    if (cont_left != 3'd0 && b[7:6] == 2'b10) begin
      partial_cp = {partial_cp[24:0], b[5:0]};
      cont_left  = cont_left - 3'd1;
      if (cont_left == 3'd0) begin
        emit_code_point(partial_cp);
        partial_cp = '0;
      end
    end else begin
      start_lead(b);
    end
    if (last) begin
      r.kind        = KIND_SUMMARY;
      r.code_unit   = '0;
      r.total_units = capacity_hit ? 16'd0 : units_in_text;
      r.overflow    = capacity_hit;
      r.run_last    = 1'b0;
      pending_units_q.push_back(r);
      partial_cp    = '0;
      cont_left     = '0;
      units_in_text = '0;
      capacity_hit  = 1'b0;
    end
    if (pending_units_q.size() > first) begin
      r = pending_units_q.pop_back();
      r.run_last = 1'b1;
      pending_units_q.push_back(r);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (result_kind_i == KIND_SUMMARY) begin
      n_summaries++;
      if (overflow_i) n_overflows++;
    end else begin
      n_units++;
    end
    if (pending_units_q.size() == 0) begin
      report_mismatch("result with none expected, code_unit", code_unit_i, 16'd0);
      return;
    end
    want = pending_units_q.pop_front();
    if (result_kind_i !== want.kind)
      report_mismatch("result_kind", {15'd0, result_kind_i}, {15'd0, want.kind});
    if (code_unit_i !== want.code_unit)
      report_mismatch("code_unit", code_unit_i, want.code_unit);
    if (total_units_i !== want.total_units)
      report_mismatch("total_units", total_units_i, want.total_units);
    if (overflow_i !== want.overflow)
      report_mismatch("overflow", {15'd0, overflow_i}, {15'd0, want.overflow});
    if (run_last_i !== want.run_last)
      report_mismatch("run_last", {15'd0, run_last_i}, {15'd0, want.run_last});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_units_q.delete();
      limit_copy    = '0;
      partial_cp    = '0;
      cont_left     = '0;
      units_in_text = '0;
      capacity_hit  = 1'b0;
      mismatch_count_o <= errors;
      expected_left_o  <= 0;
      units_seen_o     <= n_units;
      summaries_seen_o <= n_summaries;
      overflows_seen_o <= n_overflows;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_copy = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_byte(in_byte_i, end_of_text_i);
      if (out_valid_i && out_ready_i) check_result();
      mismatch_count_o <= errors;
      expected_left_o  <= pending_units_q.size();
      units_seen_o     <= n_units;
      summaries_seen_o <= n_summaries;
      overflows_seen_o <= n_overflows;
    end
  end

endmodule

// ===== dv/tb_utf8_to_utf16_transcoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Feeds UTF-8 bytes under several unit limits with random pacing on both
// channels, lets the checker predict and compare every result, and gives
// the verdict once all results have drained.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_unit;

  localparam int ClkPeriod   = 10;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 150;  // long receiver hold-off, fills the block
  localparam int MaxGap      = 10;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte  = '0;
  logic        in_eot   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [15:0] code_unit;
  logic [15:0] total_units;
  logic        overflow;
  logic        run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  int mismatches;
  int expected_left;
  int units_seen;
  int summaries_seen;
  int overflows_seen;

  // Pacing controls of the stimulus and the receiver, and stimulus counters.
  logic tx_burst    = 1'b0;
  logic rx_burst    = 1'b0;
  int   hold_reqs   = 0;
  int   bytes_sent  = 0;
  int   limits_set  = 0;

  logic [7:0] text_q[$];

  always #(ClkPeriod / 2) clk = ~clk;

  utf8_to_utf16_transcoder_unit uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_byte_i     (in_byte),
    .end_of_text_i (in_eot),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind),
    .code_unit_o   (code_unit),
    .total_units_o (total_units),
    .overflow_o    (overflow),
    .run_last_o    (run_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  utf8_to_utf16_transcoder_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_byte_i        (in_byte),
    .end_of_text_i    (in_eot),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .result_kind_i    (result_kind),
    .code_unit_i      (code_unit),
    .total_units_i    (total_units),
    .overflow_i       (overflow),
    .run_last_i       (run_last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .expected_left_o  (expected_left),
    .units_seen_o     (units_seen),
    .summaries_seen_o (summaries_seen),
    .overflows_seen_o (overflows_seen)
  );

  // Offer one byte and return at the edge that accepts it. Valid is left high
  // so that a back-to-back item just swaps the payload; lower it only when a
  // gap is drawn, never in the same step it gets raised.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eot   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid, wait until every predicted result has come out, then give
  // bytes that made no result time to clear the pipeline.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write unit_limit; only called with the block idle.
  task automatic write_limit(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limits_set++;
    @(posedge clk);
  endtask

  // Queue a lead with random payload bits and some of its continuation bytes.
  task automatic queue_multibyte(input int n_cont, input int n_give);
    logic [7:0] prefix;
    logic [7:0] payload;
    prefix  = 8'hFF << (7 - n_cont);
    payload = 8'h7F >> (n_cont + 1);
    text_q.push_back(prefix | (payload & 8'($urandom())));
    repeat (n_give) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // Add one character of a random kind, mostly well formed.
  task automatic queue_random_char();
    logic [20:0] cp;
    int          n;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4: text_q.push_back(8'($urandom_range(0, 127)));
      5, 6:          queue_multibyte(1, 1);
      7, 8:          queue_multibyte(2, 2);
      9, 10: begin
        if ($urandom_range(0, 1) == 1) begin
          cp = 21'($urandom_range(32'h1_0000, 32'h10_FFFF));
          text_q.push_back({5'b11110, cp[20:18]});
          text_q.push_back({2'b10, cp[17:12]});
          text_q.push_back({2'b10, cp[11:6]});
          text_q.push_back({2'b10, cp[5:0]});
        end else begin
          queue_multibyte(3, 3);  // may land above the code space
        end
      end
      11: begin
        n = $urandom_range(4, 5);
        queue_multibyte(n, n);
      end
      12: begin
        // surrogate code point, must be dropped
        text_q.push_back(8'hED);
        text_q.push_back({3'b101, 5'($urandom())});
        text_q.push_back({2'b10, 6'($urandom())});
      end
      13: begin
        if ($urandom_range(0, 1) == 1) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        else text_q.push_back($urandom_range(0, 1) == 1 ? 8'hFE : 8'hFF);
      end
      14: begin
        // cut a sequence short and break it with a plain ASCII byte
        n = $urandom_range(1, 5);
        queue_multibyte(n, $urandom_range(0, n - 1));
        text_q.push_back(8'($urandom_range(0, 127)));
      end
      default: text_q.push_back(8'($urandom()));
    endcase
  endtask

  // Send a random text; leave it open when finish is low so that the next
  // limit applies in the middle of the string.
  task automatic send_random_text(input int n_chars, input logic finish);
    text_q.delete();
    repeat (n_chars) queue_random_char();
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], finish && (i == text_q.size() - 1));
  endtask

  // Receiver: draw a gap per result, take a long hold-off when asked.
  initial begin : receiver
    int gap;
    int holds_done;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    #1ms;
    $display("utf8_to_utf16_transcoder_unit test failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] limit;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Count-only mode from reset: supplementary characters are counted as
    // pairs and only the summary comes out.
    tx_burst = 1'b1;
    repeat (2) begin
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
    end
    send_byte(8'h41, 1'b1);
    wait_for_drain();

    // Directed part at the widest limit.
    write_limit(16'hFFFF);
    tx_burst = 1'b0;
    send_byte(8'h00, 1'b0);                      // lowest byte
    send_byte(8'h7F, 1'b0);                      // highest one-byte form
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    // surrogate range, dropped
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    // top of the code space with end of text: pair and summary from one byte
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
    // invalid leads and a stray continuation, skipped
    send_byte(8'hFE, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
    // broken sequence: ASCII after a lead drops it and is decoded itself
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    // five-byte legacy form above the code space, dropped
    send_byte(8'hF8, 1'b0); send_byte(8'h88, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    // sequence still open at end of text, dropped
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    wait_for_drain();

    // Random phases over several limits, strings sometimes left open across
    // a limit change; each phase ends with the sender idle until drained.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       limit = 16'd0;
        1:       limit = 16'd1;
        2:       limit = 16'hFFFF;
        3:       limit = 16'd3;
        6:       limit = 16'($urandom());
        default: limit = 16'($urandom_range(2, 12));
      endcase
      write_limit(limit);
      send_random_text($urandom_range(1, 3), $urandom_range(0, 3) != 0);
      send_random_text($urandom_range(1, 3), $urandom_range(0, 3) != 0);
      wait_for_drain();
    end

    // Back-pressure: hold the receiver off while a long ASCII text streams
    // in, so the result queue fills and the input stalls.
    write_limit(16'hFFFF);
    hold_reqs++;
    tx_burst = 1'b1;
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(0, 127)), i == 15);
    wait_for_drain();

    $display("sent %0d bytes under %0d limit settings", bytes_sent, limits_set);
    $display("checked %0d code units and %0d summaries, %0d of them overflowed",
             units_seen, summaries_seen, overflows_seen);
    if (mismatches == 0 && expected_left == 0) begin
      $display("utf8_to_utf16_transcoder_unit test passed");
    end else begin
      $display("utf8_to_utf16_transcoder_unit test failed");
    end
    $finish;
  end

endmodule
